FILE: src/ntt_pkg.sv
package ntt_pkg;
	localparam int unsigned LOG2_MAX_LEN_DEF = 6;
	localparam int unsigned COEFF_W = 30;
	localparam logic [29:0] MODP = 30'd998244353;
	localparam logic [29:0] PRIM_ROOT = 30'd3;
	localparam int unsigned REG_LOG2_LEN = 0;
	localparam int unsigned REG_INVERSE = 1;

	// modular add/sub on residues
	function automatic logic [29:0] add_mod(input logic [29:0] a, input logic [29:0] b);
		logic [30:0] s;
		logic [30:0] d;
		s = {1'b0, a} + {1'b0, b};
		d = s - {1'b0, MODP};
		add_mod = (s >= {1'b0, MODP}) ? d[29:0] : s[29:0];
	endfunction

	function automatic logic [29:0] sub_mod(input logic [29:0] a, input logic [29:0] b);
		logic [30:0] d;
		d = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, MODP} - {1'b0, b});
		sub_mod = d[29:0];
	endfunction
endpackage

FILE: src/ntt_mulmod.sv
// Shared modular multiplier: 30x30 product, then Barrett reduction by the fixed
// modulus, reusing the same 32x32 multiplier for the quotient estimate and q*P.
// go is taken when idle; done pulses with p valid after the multiply, estimate, q*P and fix steps.
module ntt_mulmod (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic [ntt_pkg::COEFF_W-1:0] a,
	input  logic [ntt_pkg::COEFF_W-1:0] b,
	output logic                  done,
	output logic [ntt_pkg::COEFF_W-1:0] p
);
	import ntt_pkg::*;

	// floor(2^60 / P), fits in 31 bits
	localparam logic [31:0] BARRETT_M = 32'((64'd1 << 60) / 64'(MODP));
	localparam logic [31:0] MODP_X1 = {2'b0, MODP};
	localparam logic [31:0] MODP_X2 = {1'b0, MODP, 1'b0};

	typedef enum logic [2:0] {M_IDLE, M_MUL, M_EST, M_QP, M_FIX} mst_t;

	mst_t        st_q;
	logic [29:0] a_q, b_q, p_q;
	logic [59:0] prod_q;
	logic [31:0] quo_q;
	logic [31:0] qp_q;
	logic [31:0] mx, my;
	logic [63:0] mres;
	logic [31:0] rem;

	// one multiplier, operands picked by step
	always_comb begin
		case (st_q)
			M_EST: begin
				mx = {1'b0, prod_q[59:29]};
				my = BARRETT_M;
			end
			M_QP: begin
				mx = quo_q;
				my = MODP_X1;
			end
			default: begin
				mx = {2'b0, a_q};
				my = {2'b0, b_q};
			end
		endcase
	end

	assign mres = mx * my;
	// true remainder is below 3P, so the low 32 bits are enough
	assign rem  = prod_q[31:0] - qp_q;
	assign p    = p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= M_IDLE;
			done   <= 1'b0;
			a_q    <= '0;
			b_q    <= '0;
			p_q    <= '0;
			prod_q <= '0;
			quo_q  <= '0;
			qp_q   <= '0;
		end else begin
			done <= 1'b0;
			case (st_q)
				M_IDLE: begin
					if (go) begin
						a_q  <= a;
						b_q  <= b;
						st_q <= M_MUL;
					end
				end
				M_MUL: begin
					prod_q <= mres[59:0];
					st_q   <= M_EST;
				end
				M_EST: begin
					quo_q <= mres[62:31];
					st_q  <= M_QP;
				end
				M_QP: begin
					qp_q <= mres[31:0];
					st_q <= M_FIX;
				end
				M_FIX: begin
					if (rem >= MODP_X2) p_q <= 30'(rem - MODP_X2);
					else if (rem >= MODP_X1) p_q <= 30'(rem - MODP_X1);
					else p_q <= rem[29:0];
					done <= 1'b1;
					st_q <= M_IDLE;
				end
				default: st_q <= M_IDLE;
			endcase
		end
	end
endmodule

FILE: src/ntt_mod_998244353.sv
// The final word of a frame starts the transform: bit-reversal reorder, then per stage
// a twiddle setup (raised to the power P-2 in inverse mode) and the butterflies with
// their twiddle steps, then in inverse mode scaling by n^-1; every product goes through
// the one shared mulmod. Results are then emitted one word at a time.
// Throughput: one word per cycle while loading; busy from final word to last result.
// Reset (arst_n low, asynchronous): log2_len=6, forward mode, partial frame dropped.
module ntt_mod_998244353 #(
	parameter int unsigned LOG2_MAX_LEN = ntt_pkg::LOG2_MAX_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [ntt_pkg::COEFF_W-1:0]   coeff_in,
	output logic                          done,
	output logic [ntt_pkg::COEFF_W-1:0]   coeff_out,
	output logic                          frame_last,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [2:0]                    cfg_data
);
	import ntt_pkg::*;

	localparam int unsigned AW = LOG2_MAX_LEN;
	localparam int unsigned DEPTH = 1 << LOG2_MAX_LEN;
	localparam int unsigned LW = $clog2(LOG2_MAX_LEN + 1);

	typedef enum logic [4:0] {
		S_LOAD, S_REV_RD, S_REV_W1, S_REV_W2,
		S_TW_MUL, S_TW_WAIT, S_TWI_MUL, S_TWI_WAIT,
		S_BF_RD, S_BF_RD2, S_BF_MUL, S_BF_WAIT, S_BF_WR,
		S_W_MUL, S_W_WAIT,
		S_SC_RD, S_SC_MUL, S_SC_WAIT, S_SC_WR,
		S_EMIT_RD, S_EMIT
	} st_t;

	st_t st_q;
	logic [2:0]  log2_q;
	logic        inv_q;
	logic [AW:0] cnt_q;

	logic [29:0] mem [DEPTH];
	logic [29:0] rd_q;
	logic [AW-1:0] ra;

	logic [LW-1:0] lg_eff;
	logic [AW:0]   n_eff;
	logic [LW-1:0] stage_q;   // current len = 2^stage
	logic [4:0]    k_q;       // squaring count for twiddle, up to 22
	logic [AW:0]   i_q, j_q;
	logic [29:0]   wl_q, w_q, u_q, t_q, ninv_q;
	logic [4:0]    e_q;       // bit index for exponent P-2
	logic [29:0]   acc_q;
	// inverse twiddle: square phase when set, else multiply by wl where the bit is set
	logic          sq_q;

	logic        mgo;
	logic [29:0] ma, mb, mp;
	logic        mdone;

	ntt_mulmod u_mul (.clk(clk), .arst_n(arst_n), .go(mgo), .a(ma), .b(mb), .done(mdone), .p(mp));

	always_comb begin
		if (log2_q == 3'd0) lg_eff = LW'(1);
		else if (32'(log2_q) > LOG2_MAX_LEN) lg_eff = LW'(LOG2_MAX_LEN);
		else lg_eff = LW'(log2_q);
		n_eff = (AW+1)'(1) << lg_eff;
	end

	function automatic logic [AW-1:0] brev(input logic [AW-1:0] v, input logic [LW-1:0] bits);
		logic [AW-1:0] r;
		r = '0;
		for (int k = 0; k < AW; k++)
			if (k < int'(bits)) r[int'(bits) - 1 - k] = v[k];
		brev = r;
	endfunction

	// P-2 = 998244351
	localparam logic [29:0] PM2 = 30'd998244351;
	// exponent bases: root^((P-1)/2^s) = 3^(119*2^(23-s)); start with g=3^119, square (23-s) times
	localparam logic [29:0] G119 = 30'd15311432;

	logic [AW:0]   half;
	logic [AW-1:0] ia, ib;
	logic          tw_more;
	assign half = (AW+1)'(1) << (stage_q - LW'(1));
	assign ia = AW'(i_q + j_q);
	assign ib = AW'(i_q + j_q + half);
	assign busy = (st_q != S_LOAD);
	// more squarings still needed for this stage's twiddle
	assign tw_more = (32'(k_q) + 32'(stage_q)) < 32'd23;

	logic [29:0] cin_red;
	assign cin_red = (coeff_in >= MODP) ? (coeff_in - MODP) : coeff_in;

	always_comb begin
		mgo = 1'b0; ma = w_q; mb = rd_q;
		case (st_q)
			S_TW_MUL:  begin mgo = tw_more; ma = wl_q; mb = wl_q; end
			S_TWI_MUL: begin
				mgo = 1'b1; ma = acc_q;
				mb = sq_q ? acc_q : ((PM2[e_q]) ? wl_q : 30'd1);
			end
			S_BF_MUL:  begin mgo = 1'b1; ma = w_q; mb = rd_q; end
			S_W_MUL:   begin mgo = 1'b1; ma = w_q; mb = wl_q; end
			S_SC_MUL:  begin mgo = 1'b1; ma = rd_q; mb = ninv_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[ra];
		if (st_q == S_LOAD && start) mem[AW'(cnt_q)] <= cin_red;
		// swap: rd_q holds mem[j], u_q holds mem[i]
		if (st_q == S_REV_W2 && i_q < j_q) begin
			mem[AW'(i_q)] <= rd_q;
			mem[AW'(j_q)] <= u_q;
		end
		if (st_q == S_BF_WR) begin
			mem[ia] <= add_mod(u_q, t_q);
			mem[ib] <= sub_mod(u_q, t_q);
		end
		if (st_q == S_SC_WR) mem[AW'(i_q)] <= t_q;
	end

	always_comb begin
		ra = AW'(i_q);
		case (st_q)
			S_REV_RD: ra = AW'(i_q);
			S_REV_W1: ra = brev(AW'(i_q), lg_eff);
			S_BF_RD:  ra = ia;
			S_BF_RD2: ra = ib;
			default:  ra = AW'(i_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_LOAD; log2_q <= 3'd6; inv_q <= 1'b0; cnt_q <= '0;
			done <= 1'b0; frame_last <= 1'b0; coeff_out <= '0;
			stage_q <= '0; k_q <= '0; i_q <= '0; j_q <= '0;
			wl_q <= '0; w_q <= '0; u_q <= '0; t_q <= '0;
			e_q <= '0; acc_q <= '0; sq_q <= 1'b0;
		end else begin
			done <= 1'b0; frame_last <= 1'b0;
			if (cfg_we) begin
				if (cfg_idx == 1'(REG_LOG2_LEN)) log2_q <= cfg_data;
				else inv_q <= cfg_data[0];
			end
			// a length write drops any partial frame
			if (cfg_we && cfg_idx == 1'(REG_LOG2_LEN)) cnt_q <= '0;
			else if (st_q == S_LOAD && start)
				cnt_q <= (cnt_q + 1'b1 >= n_eff) ? '0 : cnt_q + 1'b1;
			case (st_q)
				S_LOAD: if (start) begin
					if (cnt_q + 1'b1 >= n_eff) begin
						i_q <= '0; st_q <= S_REV_RD;
					end
				end
				S_REV_RD: begin
					j_q <= (AW+1)'(brev(AW'(i_q), lg_eff));
					st_q <= S_REV_W1;
				end
				S_REV_W1: begin
					// rd_q = mem[i]; now reading mem[j]
					u_q <= rd_q;
					st_q <= S_REV_W2;
				end
				S_REV_W2: begin
					if (i_q + 1'b1 == n_eff) begin
						stage_q <= LW'(1); st_q <= S_TW_MUL;
						wl_q <= G119; k_q <= '0;
					end else begin
						i_q <= i_q + 1'b1; st_q <= S_REV_RD;
					end
				end
				S_TW_MUL: begin
					if (!tw_more) begin
						if (inv_q) begin
							acc_q <= 30'd1; e_q <= 5'd29; sq_q <= 1'b1;
							st_q <= S_TWI_MUL;
						end else begin
							i_q <= '0; j_q <= '0; w_q <= 30'd1; st_q <= S_BF_RD;
						end
					end else st_q <= S_TW_WAIT;
				end
				S_TW_WAIT: if (mdone) begin
					wl_q <= mp; k_q <= k_q + 5'd1; st_q <= S_TW_MUL;
				end
				S_TWI_MUL: st_q <= S_TWI_WAIT;
				S_TWI_WAIT: if (mdone) begin
					acc_q <= mp;
					if (sq_q) begin
						sq_q <= 1'b0; st_q <= S_TWI_MUL;
					end else if (e_q == 5'd0) begin
						wl_q <= mp; i_q <= '0; j_q <= '0; w_q <= 30'd1; st_q <= S_BF_RD;
					end else begin
						e_q <= e_q - 1'b1; sq_q <= 1'b1; st_q <= S_TWI_MUL;
					end
				end
				S_BF_RD:  st_q <= S_BF_RD2;
				S_BF_RD2: begin u_q <= rd_q; st_q <= S_BF_MUL; end
				S_BF_MUL: st_q <= S_BF_WAIT;
				S_BF_WAIT: if (mdone) begin t_q <= mp; st_q <= S_BF_WR; end
				S_BF_WR: begin
					if (j_q + 1'b1 == half) begin
						j_q <= '0; w_q <= 30'd1;
						if (i_q + (half << 1) >= n_eff) begin
							i_q <= '0;
							if (stage_q == lg_eff) begin
								st_q <= inv_q ? S_SC_RD : S_EMIT_RD;
							end else begin
								stage_q <= stage_q + 1'b1; wl_q <= G119; k_q <= '0;
								st_q <= S_TW_MUL;
							end
						end else begin
							i_q <= i_q + (half << 1); st_q <= S_BF_RD;
						end
					end else begin
						j_q <= j_q + 1'b1; st_q <= S_W_MUL;
					end
				end
				S_W_MUL: st_q <= S_W_WAIT;
				S_W_WAIT: if (mdone) begin w_q <= mp; st_q <= S_BF_RD; end
				S_SC_RD:  st_q <= S_SC_MUL;
				S_SC_MUL: st_q <= S_SC_WAIT;
				S_SC_WAIT: if (mdone) begin t_q <= mp; st_q <= S_SC_WR; end
				S_SC_WR: begin
					if (i_q + 1'b1 == n_eff) begin i_q <= '0; st_q <= S_EMIT_RD; end
					else begin i_q <= i_q + 1'b1; st_q <= S_SC_RD; end
				end
				S_EMIT_RD: st_q <= S_EMIT;
				S_EMIT: begin
					done <= 1'b1; coeff_out <= rd_q;
					if (i_q + 1'b1 == n_eff) begin
						frame_last <= 1'b1; st_q <= S_LOAD;
					end else begin
						i_q <= i_q + 1'b1; st_q <= S_EMIT_RD;
					end
				end
				default: st_q <= S_LOAD;
			endcase
		end
	end

	// n^-1 = (P+1)/2^lg mod P = P - (P-1)/2^lg
	always_ff @(posedge clk) begin
		ninv_q <= MODP - 30'((30'd998244352) >> lg_eff);
	end
endmodule
